[design/lmsa_pkg.sv]
// ----------------------------------------------------------------------------
// lmsa_pkg
// Shared types, status codes and rounding helpers for the landmark
// similarity alignment core.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsa_pkg;

    localparam int NUM_LM    = 4;
    localparam int NUM_COORD = 2 * NUM_LM;

    typedef logic signed [63:0] s64_t;
    typedef logic signed [31:0] s32_t;
    typedef logic [1:0]         status_t;

    localparam status_t STAT_SEED     = 2'd0;
    localparam status_t STAT_ALIGN    = 2'd1;
    localparam status_t STAT_MISSING  = 2'd2;
    localparam status_t STAT_SINGULAR = 2'd3;

    typedef struct packed {
        logic en;
        logic mode;   // 0: fit sums, 1: apply transform
    } lane_ctl_t;

    function automatic s32_t sat32(input s64_t v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // v / 4, nearest with halves away from zero, saturated to 32 bits
    function automatic s32_t rnd_div4_sat(input s64_t v);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] lim;
        logic [31:0] qs;
        neg = v[63];
        mag = neg ? (64'd0 - v) : v;
        q   = (mag >> 2) + {63'd0, mag[1]};
        lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        qs  = (q > lim) ? lim[31:0] : q[31:0];
        return neg ? (32'd0 - qs) : qs;
    endfunction

endpackage

`default_nettype wire

[design/lmsa_lane.sv]
// ----------------------------------------------------------------------------
// lmsa_lane
// Per-landmark arithmetic: fit cross products or the aligned point.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsa_lane #(
    parameter int CW = 16
) (
    input  wire                   aclk,
    input  wire lmsa_pkg::lane_ctl_t ctl,
    input  wire signed [CW-1:0]   x,
    input  wire signed [CW-1:0]   y,
    input  wire signed [31:0]     mx,
    input  wire signed [31:0]     my,
    input  wire signed [31:0]     a,
    input  wire signed [31:0]     b,
    input  wire signed [31:0]     tx,
    input  wire signed [31:0]     ty,
    output lmsa_pkg::s64_t        p_reg,
    output lmsa_pkg::s64_t        q_reg,
    output lmsa_pkg::s64_t        sq_reg
);

    logic signed [31:0]    op_a, op_b, op_c, op_d;
    logic signed [CW+31:0] m1, m2, m3, m4;
    logic signed [2*CW-1:0] xx, yy;
    lmsa_pkg::s64_t        p_next, q_next, sq_next;

    always_comb begin
        op_a = ctl.mode ? a : mx;
        op_b = ctl.mode ? b : my;
        op_c = ctl.mode ? b : my;
        op_d = ctl.mode ? a : mx;
        m1 = x * op_a;
        m2 = y * op_b;
        m3 = x * op_c;
        m4 = y * op_d;
        xx = x * x;
        yy = y * y;
        sq_next = 64'(xx) + 64'(yy);
        if (ctl.mode) begin
            p_next = 64'(m1) - 64'(m2) + 64'(tx);
            q_next = 64'(m3) + 64'(m4) + 64'(ty);
        end else begin
            p_next = 64'(m1) + 64'(m2);
            q_next = 64'(m3) - 64'(m4);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            p_reg  <= p_next;
            q_reg  <= q_next;
            sq_reg <= sq_next;
        end
    end

endmodule

`default_nettype wire

[design/lmsa_merge.sv]
// ----------------------------------------------------------------------------
// lmsa_merge
// Combines lane results into the sums of the closed-form fit.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsa_merge #(
    parameter int CW = 16
) (
    input  wire                   aclk,
    input  wire                   en,
    input  wire signed [CW-1:0]   x  [lmsa_pkg::NUM_LM],
    input  wire signed [CW-1:0]   y  [lmsa_pkg::NUM_LM],
    input  wire signed [31:0]     mx [lmsa_pkg::NUM_LM],
    input  wire signed [31:0]     my [lmsa_pkg::NUM_LM],
    input  wire lmsa_pkg::s64_t   lp [lmsa_pkg::NUM_LM],
    input  wire lmsa_pkg::s64_t   lq [lmsa_pkg::NUM_LM],
    input  wire lmsa_pkg::s64_t   lsq[lmsa_pkg::NUM_LM],
    output logic signed [CW+1:0]  sx_reg,
    output logic signed [CW+1:0]  sy_reg,
    output logic signed [33:0]    smx_reg,
    output logic signed [33:0]    smy_reg,
    output lmsa_pkg::s64_t        sq_reg,
    output lmsa_pkg::s64_t        pa_reg,
    output lmsa_pkg::s64_t        pb_reg
);

    logic signed [CW+1:0] sx_next, sy_next;
    logic signed [33:0]   smx_next, smy_next;
    lmsa_pkg::s64_t       sq_next, pa_next, pb_next;

    always_comb begin
        sx_next = '0; sy_next = '0; smx_next = '0; smy_next = '0;
        sq_next = '0; pa_next = '0; pb_next = '0;
        for (int k = 0; k < lmsa_pkg::NUM_LM; k++) begin
            sx_next  = sx_next  + (CW+2)'(x[k]);
            sy_next  = sy_next  + (CW+2)'(y[k]);
            smx_next = smx_next + 34'(mx[k]);
            smy_next = smy_next + 34'(my[k]);
            sq_next  = sq_next  + lsq[k];
            pa_next  = pa_next  + lp[k];
            pb_next  = pb_next  + lq[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            smx_reg <= smx_next;
            smy_reg <= smy_next;
            sq_reg  <= sq_next;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
        end
    end

endmodule

`default_nettype wire

[design/lmsa_div.sv]
// ----------------------------------------------------------------------------
// lmsa_div
// Bit-serial signed / unsigned divider, round half away, 32-bit saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsa_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 start,
    input  wire lmsa_pkg::s64_t num,
    input  wire [63:0]          den,
    output logic                done_reg,
    output lmsa_pkg::s32_t      res_reg
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} dstate_t;

    dstate_t     state_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [63:0] den_reg, quo_reg, rem_reg;

    logic [64:0] rem_sh;
    logic        ge;
    logic [63:0] rem_next, quo_next;
    logic        rnd;
    logic [64:0] qr, lim;
    logic [31:0] qs;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[63]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? 64'(rem_sh - {1'b0, den_reg}) : rem_sh[63:0];
        quo_next = {quo_reg[62:0], ge};
        rnd      = {rem_reg, 1'b0} >= {1'b0, den_reg};
        qr       = {1'b0, quo_reg} + {64'd0, rnd};
        lim      = neg_reg ? 65'h0_8000_0000 : 65'h0_7FFF_FFFF;
        qs       = (qr > lim) ? lim[31:0] : qr[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= (state_reg == S_FIN);
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        neg_reg   <= num[63];
                        quo_reg   <= num[63] ? (64'd0 - num) : num;
                        rem_reg   <= '0;
                        den_reg   <= den;
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    res_reg   <= neg_reg ? (32'd0 - qs) : qs;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/landmark_similarity_align_mean_core.sv]
// ----------------------------------------------------------------------------
// landmark_similarity_align_mean_core
// Least-squares similarity fit of a four-point face to a running mean.
// ----------------------------------------------------------------------------
// Work per face: a fitted face runs ten divisions in the shared bit-serial
//   divider (a, b and eight means); a rejected, seeding or singular face
//   runs none.
// Throughput: one face at a time, four result beats per face.
// Reset: synchronous active-low aresetn clears sums, means and face count.
`default_nettype none

module landmark_similarity_align_mean_core #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire signed [COORD_WIDTH-1:0] s_left_eye_x,
    input  wire signed [COORD_WIDTH-1:0] s_left_eye_y,
    input  wire signed [COORD_WIDTH-1:0] s_right_eye_x,
    input  wire signed [COORD_WIDTH-1:0] s_right_eye_y,
    input  wire signed [COORD_WIDTH-1:0] s_nose_x,
    input  wire signed [COORD_WIDTH-1:0] s_nose_y,
    input  wire signed [COORD_WIDTH-1:0] s_mouth_x,
    input  wire signed [COORD_WIDTH-1:0] s_mouth_y,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [1:0]                   m_status,
    output logic [1:0]                   m_landmark,
    output logic signed [31:0]           m_mean_x,
    output logic signed [31:0]           m_mean_y,
    output logic signed [31:0]           m_scale_cos,
    output logic signed [31:0]           m_scale_sin,
    output logic signed [31:0]           m_shift_x,
    output logic signed [31:0]           m_shift_y,
    output logic                         m_last
);

    localparam int CW = COORD_WIDTH;
    localparam int NL = lmsa_pkg::NUM_LM;
    localparam int NC = lmsa_pkg::NUM_COORD;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LANE0, ST_MERGE, ST_PROD, ST_NUM, ST_DIVA, ST_DIVB,
        ST_TPROD, ST_TX, ST_LANE1, ST_ACC, ST_MEAN, ST_LOAD, ST_OUT
    } state_t;

    state_t                   state_reg;
    logic signed [CW-1:0]     pt_reg   [NC];
    lmsa_pkg::s64_t           sum_reg  [NC];
    lmsa_pkg::s32_t           mean_reg [NC];
    lmsa_pkg::s32_t           omean_reg[NC];
    logic [COUNT_WIDTH-1:0]   total_reg;
    lmsa_pkg::status_t        status_reg;
    lmsa_pkg::s32_t           a_reg, b_reg, tx_reg, ty_reg;
    lmsa_pkg::s64_t           sxx_reg, syy_reg, sxm_reg, sym_reg, sxmy_reg, symx_reg;
    lmsa_pkg::s64_t           d_reg, na_reg, nb_reg;
    logic signed [CW+33:0]    asx_reg, bsy_reg, bsx_reg, asy_reg;
    logic                     div_go_reg;
    logic [2:0]               idx_reg;
    logic [1:0]               beat_reg;

    logic signed [CW-1:0]     in_pt[NC];
    logic                     missing;
    lmsa_pkg::lane_ctl_t      lane_ctl;
    logic                     merge_en;
    lmsa_pkg::s64_t           lp[NL], lq[NL], lsq[NL];
    logic signed [CW-1:0]     lx[NL], ly[NL];
    logic signed [31:0]       lmx[NL], lmy[NL];
    logic signed [CW+1:0]     sx, sy;
    logic signed [33:0]       smx, smy;
    lmsa_pkg::s64_t           sq, pa, pb;
    logic                     div_start;
    lmsa_pkg::s64_t           div_num;
    logic [63:0]              div_den;
    logic                     div_done;
    lmsa_pkg::s32_t           div_res;
    lmsa_pkg::s64_t           seed_v[NC];
    logic signed [CW+33:0]    asx_next, bsy_next, bsx_next, asy_next;

    always_comb begin
        in_pt[0] = s_left_eye_x;  in_pt[1] = s_left_eye_y;
        in_pt[2] = s_right_eye_x; in_pt[3] = s_right_eye_y;
        in_pt[4] = s_nose_x;      in_pt[5] = s_nose_y;
        in_pt[6] = s_mouth_x;     in_pt[7] = s_mouth_y;
        missing = 1'b0;
        for (int k = 0; k < NL; k++) begin
            if (in_pt[2*k] == '0 && in_pt[2*k+1] == '0) begin
                missing = 1'b1;
            end
            lx[k]  = pt_reg[2*k];
            ly[k]  = pt_reg[2*k+1];
            lmx[k] = mean_reg[2*k];
            lmy[k] = mean_reg[2*k+1];
        end
        for (int i = 0; i < NC; i++) begin
            seed_v[i] = 64'(in_pt[i]) <<< FRAC_BITS;
        end
        lane_ctl.en   = (state_reg == ST_LANE0) || (state_reg == ST_LANE1);
        lane_ctl.mode = (state_reg == ST_LANE1);
        merge_en      = (state_reg == ST_MERGE);
        div_start = !div_go_reg && ((state_reg == ST_DIVA && d_reg > 0) ||
                    state_reg == ST_DIVB || state_reg == ST_MEAN);
        unique case (state_reg)
            ST_DIVA: div_num = na_reg;
            ST_DIVB: div_num = nb_reg;
            default: div_num = sum_reg[idx_reg];
        endcase
        div_den = (state_reg == ST_MEAN) ? 64'(total_reg) : d_reg;
        asx_next = a_reg * sx;
        bsy_next = b_reg * sy;
        bsx_next = b_reg * sx;
        asy_next = a_reg * sy;
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        lmsa_lane #(.CW(CW)) u_lane (
            .aclk  (aclk),
            .ctl   (lane_ctl),
            .x     (lx[g]),
            .y     (ly[g]),
            .mx    (lmx[g]),
            .my    (lmy[g]),
            .a     (a_reg),
            .b     (b_reg),
            .tx    (tx_reg),
            .ty    (ty_reg),
            .p_reg (lp[g]),
            .q_reg (lq[g]),
            .sq_reg(lsq[g])
        );
    end

    lmsa_merge #(.CW(CW)) u_merge (
        .aclk   (aclk),
        .en     (merge_en),
        .x      (lx),
        .y      (ly),
        .mx     (lmx),
        .my     (lmy),
        .lp     (lp),
        .lq     (lq),
        .lsq    (lsq),
        .sx_reg (sx),
        .sy_reg (sy),
        .smx_reg(smx),
        .smy_reg(smy),
        .sq_reg (sq),
        .pa_reg (pa),
        .pb_reg (pb)
    );

    lmsa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done_reg(div_done),
        .res_reg (div_res)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_OUT);
    assign m_status    = status_reg;
    assign m_landmark  = beat_reg;
    assign m_mean_x    = omean_reg[0];
    assign m_mean_y    = omean_reg[1];
    assign m_scale_cos = a_reg;
    assign m_scale_sin = b_reg;
    assign m_shift_x   = tx_reg;
    assign m_shift_y   = ty_reg;
    assign m_last      = (beat_reg == 2'(NL - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            total_reg  <= '0;
            div_go_reg <= 1'b0;
            idx_reg    <= '0;
            beat_reg   <= '0;
            for (int i = 0; i < NC; i++) begin
                sum_reg[i]  <= '0;
                mean_reg[i] <= '0;
            end
        end else begin
            if (div_start) begin
                div_go_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        a_reg  <= '0;
                        b_reg  <= '0;
                        tx_reg <= '0;
                        ty_reg <= '0;
                        for (int i = 0; i < NC; i++) begin
                            pt_reg[i] <= in_pt[i];
                        end
                        if (missing) begin
                            status_reg <= lmsa_pkg::STAT_MISSING;
                            state_reg  <= ST_LOAD;
                        end else if (total_reg == '0) begin
                            for (int i = 0; i < NC; i++) begin
                                sum_reg[i]  <= seed_v[i];
                                mean_reg[i] <= lmsa_pkg::sat32(seed_v[i]);
                            end
                            total_reg  <= COUNT_WIDTH'(1);
                            status_reg <= lmsa_pkg::STAT_SEED;
                            state_reg  <= ST_LOAD;
                        end else begin
                            state_reg <= ST_LANE0;
                        end
                    end
                end
                ST_LANE0: state_reg <= ST_MERGE;
                ST_MERGE: state_reg <= ST_PROD;
                ST_PROD: begin
                    sxx_reg  <= 64'(sx * sx);
                    syy_reg  <= 64'(sy * sy);
                    sxm_reg  <= 64'(sx * smx);
                    sym_reg  <= 64'(sy * smy);
                    sxmy_reg <= 64'(sx * smy);
                    symx_reg <= 64'(sy * smx);
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    d_reg  <= (sq <<< 2) - sxx_reg - syy_reg;
                    na_reg <= (pa <<< 2) - sxm_reg - sym_reg;
                    nb_reg <= (pb <<< 2) - sxmy_reg + symx_reg;
                    state_reg <= ST_DIVA;
                end
                ST_DIVA: begin
                    if (d_reg <= 0) begin
                        status_reg <= lmsa_pkg::STAT_SINGULAR;
                        state_reg  <= ST_LOAD;
                    end else if (div_done) begin
                        a_reg      <= div_res;
                        div_go_reg <= 1'b0;
                        state_reg  <= ST_DIVB;
                    end
                end
                ST_DIVB: begin
                    if (div_done) begin
                        b_reg      <= div_res;
                        div_go_reg <= 1'b0;
                        state_reg  <= ST_TPROD;
                    end
                end
                ST_TPROD: begin
                    asx_reg   <= asx_next;
                    bsy_reg   <= bsy_next;
                    bsx_reg   <= bsx_next;
                    asy_reg   <= asy_next;
                    state_reg <= ST_TX;
                end
                ST_TX: begin
                    tx_reg <= lmsa_pkg::rnd_div4_sat(64'(smx) - 64'(asx_reg) + 64'(bsy_reg));
                    ty_reg <= lmsa_pkg::rnd_div4_sat(64'(smy) - 64'(bsx_reg) - 64'(asy_reg));
                    state_reg <= ST_LANE1;
                end
                ST_LANE1: state_reg <= ST_ACC;
                ST_ACC: begin
                    for (int k = 0; k < NL; k++) begin
                        sum_reg[2*k]   <= sum_reg[2*k]   + lp[k];
                        sum_reg[2*k+1] <= sum_reg[2*k+1] + lq[k];
                    end
                    if (total_reg != '1) begin
                        total_reg <= total_reg + COUNT_WIDTH'(1);
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_MEAN;
                end
                ST_MEAN: begin
                    if (div_done) begin
                        mean_reg[idx_reg] <= div_res;
                        div_go_reg        <= 1'b0;
                        idx_reg           <= idx_reg + 3'd1;
                        if (idx_reg == 3'(NC - 1)) begin
                            status_reg <= lmsa_pkg::STAT_ALIGN;
                            state_reg  <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    for (int i = 0; i < NC; i++) begin
                        omean_reg[i] <= mean_reg[i];
                    end
                    beat_reg  <= '0;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        // shift next landmark pair into the output slot
                        for (int i = 0; i < NC - 2; i++) begin
                            omean_reg[i] <= omean_reg[i+2];
                        end
                        beat_reg <= beat_reg + 2'd1;
                        if (beat_reg == 2'(NL - 1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
